[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules of the segment table core.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

[rtl/sscrt_pkg.sv]
// Types and fixed constants of the shared segment reference-count table core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package sscrt_pkg;

    // Status codes of a result beat
    localparam logic [2:0] ST_NEW         = 3'd0;
    localparam logic [2:0] ST_EXISTING    = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [2:0] ST_SPACE_FULL  = 3'd3;
    localparam logic [2:0] ST_DECREMENTED = 3'd4;
    localparam logic [2:0] ST_FREED       = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd6;

    // Request kinds
    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] seg_id;
        logic [19:0] new_frame;
        logic [30:0] proc_size;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [19:0] frame_out;
        logic [30:0] map_address;
        logic [30:0] new_proc_size;
        logic [15:0] ref_count;
    } t_res;

    typedef struct packed {
        logic [31:0] id;
        logic [19:0] frame;
        logic [15:0] count;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic scan_done;
    } t_sts;

endpackage

`default_nettype wire

[rtl/shared_segment_refcount_table_core.sv]
// Top level of the shared segment reference-count table core.
// Depends on sscrt_pkg, sscrt_ctrl and sscrt_dp.
//
//   channel   handshake           payload          direction
//   request   start / busy        i_req  (t_req)   in
//   result    o_res_strobe        o_res  (t_res)   out
//
// After reset the table is cleared one entry a cycle, busy staying high
// throughout. A request's result beat comes after a serial scan over the
// one read port of the entry memory; an open or close that hits an id
// early ends its scan there.
// busy stays low again in the cycle the result beat is shown. The receiver
// cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module shared_segment_refcount_table_core #(
    parameter int ENTRIES   = 64,
    parameter int PAGE_BITS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire sscrt_pkg::t_req i_req,
    output sscrt_pkg::t_res     o_res,
    output logic                o_res_strobe
);

    sscrt_pkg::t_cmd cmd;
    sscrt_pkg::t_sts sts;

    sscrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sscrt_dp #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule

`default_nettype wire

[rtl/sscrt_ctrl.sv]
// Controller of the segment table core: clearing pass, scan and finish steps.
// Depends on sscrt_pkg for the command and status structs.
`default_nettype none

`include "assert_macros.svh"

module sscrt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire sscrt_pkg::t_sts i_sts,
    output sscrt_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Pick the next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands
    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH);
    end

    assign busy = (r_state != S_IDLE);

    `ASSERT_SYNC(a_finish_after_scan, i_clk, i_rst_n,
        (r_state == S_FINISH) |-> ($past(r_state) == S_SCAN),
        "finish step entered without a scan")
    `ASSERT_SYNC(a_load_leaves_idle, i_clk, i_rst_n,
        o_cmd.load |=> (r_state == S_SCAN), "accepted request did not start a scan")
    `ASSERT_NEVER(a_load_while_busy, i_clk, i_rst_n,
        o_cmd.load && busy, "request accepted while busy")

endmodule

`default_nettype wire

[rtl/sscrt_dp.sv]
// Datapath of the segment table core: entry memory, scan compare, pick
// registers, result build and write back. Depends on sscrt_pkg.
`default_nettype none

`include "assert_macros.svh"

module sscrt_dp #(
    parameter int ENTRIES   = 64,
    parameter int PAGE_BITS = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sscrt_pkg::t_cmd i_cmd,
    input  wire sscrt_pkg::t_req i_req,
    output sscrt_pkg::t_sts     o_sts,
    output sscrt_pkg::t_res     o_res,
    output logic                o_res_strobe
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [31:0] PageMask = 32'((1 << PAGE_BITS) - 1);
    localparam logic [32:0] PageSize = 33'(1 << PAGE_BITS);

    sscrt_pkg::t_entry r_mem [ENTRIES];
    sscrt_pkg::t_entry r_rd_data;

    logic [IW:0]       r_addr;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic              r_found;
    logic              r_hit;
    logic              r_seen;
    logic [IW-1:0]     r_pick;
    sscrt_pkg::t_entry r_pent;
    sscrt_pkg::t_req   r_req;
    logic [31:0]       r_map;
    sscrt_pkg::t_res   r_res;
    logic              r_res_vld;

    logic              issue;
    logic [31:0]       n_map_sum;
    logic [32:0]       n_grow;
    logic              n_space_full;
    logic              n_wr_en;
    logic [IW-1:0]     n_wr_addr;
    sscrt_pkg::t_entry n_wr_ent;
    sscrt_pkg::t_res   n_res;
    logic              is_free;
    logic              is_match;

    assign issue     = (r_addr < (IW + 1)'(ENTRIES));
    assign n_map_sum = {1'b0, i_req.proc_size} + PageMask;
    assign is_free   = (r_rd_data.count == 16'd0);
    assign is_match  = (r_rd_data.id == r_req.seg_id);

    // Advance the address counter, track the pick over read beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_cmd.load) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_addr   <= r_addr + 1'b1;
        end else if (i_cmd.scan) begin
            r_rd_vld <= issue;
            if (issue) r_addr <= r_addr + 1'b1;
            if (r_rd_vld && !r_hit) begin
                if (is_match) begin
                    r_found <= 1'b1;
                    r_hit   <= 1'b1;
                end else if (is_free && (r_req.kind == sscrt_pkg::KIND_OPEN)) begin
                    r_found <= 1'b1;
                end
                if (r_rd_idx == IW'(ENTRIES - 1)) r_seen <= 1'b1;
            end
        end
    end

    // Hold the request and the picked entry
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IW-1:0];
        if (i_cmd.load) begin
            r_req <= i_req;
            r_map <= n_map_sum & ~PageMask;
        end
        if (i_cmd.scan && r_rd_vld && !r_hit &&
            (is_match || (is_free && (r_req.kind == sscrt_pkg::KIND_OPEN)))) begin
            r_pick <= r_rd_idx;
            r_pent <= r_rd_data;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_wr_en) r_mem[n_wr_addr] <= n_wr_ent;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr[IW-1:0]];
    end

    // Build the result and the write-back entry
    always_comb begin
        n_grow       = {1'b0, r_map} + PageSize;
        n_space_full = (n_grow[32:31] != 2'b00);
        n_res        = '0;
        n_wr_en      = 1'b0;
        n_wr_addr    = r_pick;
        n_wr_ent     = r_pent;
        if (i_cmd.clear) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_addr[IW-1:0];
            n_wr_ent  = '0;
        end else if (r_req.kind == sscrt_pkg::KIND_OPEN) begin
            if (!r_found) begin
                n_res.status = sscrt_pkg::ST_TABLE_FULL;
            end else if (n_space_full) begin
                n_res.status = sscrt_pkg::ST_SPACE_FULL;
            end else begin
                n_res.slot          = 6'(r_pick);
                n_res.map_address   = r_map[30:0];
                n_res.new_proc_size = n_grow[30:0];
                n_wr_en             = i_cmd.finish;
                if (r_pent.count == 16'd0) begin
                    n_wr_ent.id     = r_req.seg_id;
                    n_wr_ent.frame  = r_req.new_frame;
                    n_wr_ent.count  = 16'd1;
                    n_res.status    = sscrt_pkg::ST_NEW;
                    n_res.frame_out = r_req.new_frame;
                    n_res.ref_count = 16'd1;
                end else begin
                    if (r_pent.count != sscrt_pkg::COUNT_MAX) begin
                        n_wr_ent.count = r_pent.count + 16'd1;
                    end
                    n_res.status    = sscrt_pkg::ST_EXISTING;
                    n_res.frame_out = r_pent.frame;
                    n_res.ref_count = n_wr_ent.count;
                end
            end
        end else begin
            if (!r_hit || (r_pent.count == 16'd0)) begin
                n_res.status = sscrt_pkg::ST_NOT_FOUND;
            end else begin
                n_res.slot      = 6'(r_pick);
                n_res.frame_out = r_pent.frame;
                n_wr_en         = i_cmd.finish;
                if (r_pent.count > 16'd1) begin
                    n_wr_ent.count  = r_pent.count - 16'd1;
                    n_res.status    = sscrt_pkg::ST_DECREMENTED;
                    n_res.ref_count = n_wr_ent.count;
                end else begin
                    n_wr_ent     = '0;
                    n_res.status = sscrt_pkg::ST_FREED;
                end
            end
        end
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.finish;
        end
        if (i_cmd.finish) r_res <= n_res;
    end

    assign o_res           = r_res;
    assign o_res_strobe    = r_res_vld;
    assign o_sts.clear_last = (r_addr == (IW + 1)'(ENTRIES - 1));
    assign o_sts.scan_done = r_hit || r_seen;

    `ASSERT_SYNC(a_strobe_after_finish, i_clk, i_rst_n,
        r_res_vld |-> $past(i_cmd.finish), "result beat without a finish step")
    `ASSERT_SYNC(a_hit_implies_found, i_clk, i_rst_n,
        r_hit |-> r_found, "id match recorded without a pick")
    `ASSERT_NEVER(a_addr_in_range, i_clk, i_rst_n,
        r_addr > (IW + 1)'(ENTRIES), "scan address ran past the table")

endmodule

`default_nettype wire

[test/tb_shared_segment_refcount_table_core.sv]
// Self-checking testbench for shared_segment_refcount_table_core.
// Needs sscrt_pkg; predicts every result beat and compares it field by field.
`timescale 1ns / 100ps

module tb_shared_segment_refcount_table_core;

    localparam int          ENTRIES     = 64;
    localparam int          PAGE_BITS   = 12;
    localparam longint      PAGE_SIZE   = 64'd1 << PAGE_BITS;
    localparam longint      SPACE_TOP   = 64'h7FFF_FFFF;
    localparam int          POOL_DEPTH  = 128;
    localparam int          CYCLE_LIMIT = 2_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    sscrt_pkg::t_req   req_beat = '0;
    sscrt_pkg::t_res   o_res;
    logic              o_res_strobe;

    // Shadow of the segment table
    logic [31:0] shadow_id    [ENTRIES];
    logic [19:0] shadow_frame [ENTRIES];
    logic [15:0] shadow_refs  [ENTRIES];

    sscrt_pkg::t_res pending_replies [$];
    logic [31:0] id_pool [POOL_DEPTH];
    int          idle_pct = 0;
    int          error_count = 0;
    int          reply_count = 0;
    int          request_count = 0;
    int          cycle_count = 0;
    int          status_seen [8];

    shared_segment_refcount_table_core #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (req_beat),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one request to the shadow table and return the beat it owes
    function automatic sscrt_pkg::t_res apply_segment_request(input sscrt_pkg::t_req r);
        sscrt_pkg::t_res res;
        int     i;
        int     pick;
        bit     found;
        longint map_addr;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        if (r.kind == sscrt_pkg::KIND_OPEN) begin
            // first matching id wins, else the last free entry
            for (i = 0; i < ENTRIES; i++) begin
                if (shadow_refs[i] == 16'd0) begin
                    pick  = i;
                    found = 1'b1;
                end
                if (shadow_id[i] == r.seg_id) begin
                    pick  = i;
                    found = 1'b1;
                    break;
                end
            end
            map_addr = (longint'(r.proc_size) + PAGE_SIZE - 1) & ~(PAGE_SIZE - 1);
            if (!found) begin
                res.status = sscrt_pkg::ST_TABLE_FULL;
            end else if (map_addr + PAGE_SIZE > SPACE_TOP) begin
                res.status = sscrt_pkg::ST_SPACE_FULL;
            end else begin
                if (shadow_refs[pick] == 16'd0) begin
                    shadow_id[pick]    = r.seg_id;
                    shadow_frame[pick] = r.new_frame;
                    shadow_refs[pick]  = 16'd1;
                    res.status         = sscrt_pkg::ST_NEW;
                end else begin
                    if (shadow_refs[pick] != sscrt_pkg::COUNT_MAX) begin
                        shadow_refs[pick] = shadow_refs[pick] + 16'd1;
                    end
                    res.status = sscrt_pkg::ST_EXISTING;
                end
                res.slot          = pick[5:0];
                res.frame_out     = shadow_frame[pick];
                res.map_address   = map_addr[30:0];
                res.new_proc_size = 31'(map_addr + PAGE_SIZE);
                res.ref_count     = shadow_refs[pick];
            end
        end else begin
            pick = -1;
            for (i = 0; i < ENTRIES; i++) begin
                if (shadow_id[i] == r.seg_id) begin
                    pick = i;
                    break;
                end
            end
            if (pick < 0 || shadow_refs[pick] == 16'd0) begin
                res.status = sscrt_pkg::ST_NOT_FOUND;
            end else begin
                res.slot      = pick[5:0];
                res.frame_out = shadow_frame[pick];
                if (shadow_refs[pick] > 16'd1) begin
                    shadow_refs[pick] = shadow_refs[pick] - 16'd1;
                    res.status        = sscrt_pkg::ST_DECREMENTED;
                    res.ref_count     = shadow_refs[pick];
                end else begin
                    shadow_id[pick]    = '0;
                    shadow_frame[pick] = '0;
                    shadow_refs[pick]  = '0;
                    res.status         = sscrt_pkg::ST_FREED;
                end
            end
        end
        return res;
    endfunction

    function automatic sscrt_pkg::t_req make_req(input logic kind, input logic [31:0] id,
                                                 input logic [19:0] frame,
                                                 input logic [30:0] psize);
        sscrt_pkg::t_req r;
        r.kind      = kind;
        r.seg_id    = id;
        r.new_frame = frame;
        r.proc_size = psize;
        return r;
    endfunction

    // Count the free entries of the shadow table
    function automatic int count_free();
        int n;
        int i;
        n = 0;
        for (i = 0; i < ENTRIES; i++) begin
            if (shadow_refs[i] == 16'd0) n++;
        end
        return n;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0d: %s", cycle_count, what);
        end
    endtask

    // Present one request beat and hold it until the core takes it
    task automatic issue_request(input sscrt_pkg::t_req r);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(90, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        req_beat <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_replies.push_back(apply_segment_request(r));
        request_count++;
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        sscrt_pkg::t_res want;
        string diffs;
        if (i_rst_n && o_res_strobe === 1'b1) begin
            reply_count++;
            status_seen[o_res.status]++;
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("result beat with nothing pending, status %0d",
                                     o_res.status));
            end else begin
                want  = pending_replies.pop_front();
                diffs = "";
                if (o_res.status !== want.status)
                    diffs = {diffs, $sformatf(" status exp %0d got %0d",
                                              want.status, o_res.status)};
                if (o_res.slot !== want.slot)
                    diffs = {diffs, $sformatf(" slot exp %0d got %0d",
                                              want.slot, o_res.slot)};
                if (o_res.frame_out !== want.frame_out)
                    diffs = {diffs, $sformatf(" frame exp %h got %h",
                                              want.frame_out, o_res.frame_out)};
                if (o_res.map_address !== want.map_address)
                    diffs = {diffs, $sformatf(" map exp %h got %h",
                                              want.map_address, o_res.map_address)};
                if (o_res.new_proc_size !== want.new_proc_size)
                    diffs = {diffs, $sformatf(" size exp %h got %h",
                                              want.new_proc_size, o_res.new_proc_size)};
                if (o_res.ref_count !== want.ref_count)
                    diffs = {diffs, $sformatf(" count exp %0d got %0d",
                                              want.ref_count, o_res.ref_count)};
                if (diffs != "")
                    flag_error($sformatf("result %0d:%s", reply_count, diffs));
            end
        end
    end

    task automatic apply_reset();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            shadow_id[i]    = '0;
            shadow_frame[i] = '0;
            shadow_refs[i]  = '0;
        end
        for (i = 0; i < 8; i++) status_seen[i] = 0;
        for (i = 0; i < POOL_DEPTH; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Extremes, every status but table full, and the free-entry and id-zero corner cases
    task automatic test_directed();
        idle_pct = 0;
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h0, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h5A5A_A5A5, 20'hFFFFF,
                               31'h7FFF_FFFF));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h0, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h0, 20'hFFFFF, 31'h1));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'hFFFF_FFFF, 20'hFFFFF,
                               31'h7FFF_E000));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'hA5A5_A5A5, 20'h5A5A5,
                               31'h7FFF_E001));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'hFFFF_FFFF, 20'h12345,
                               31'h7FFF_FFFF));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'hFFFF_FFFF, 20'h0, 31'h1000));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h0, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h0, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h0, 20'h0, 31'h0));
        // free entry whose id is zero is taken as the match and reallocated
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h0, 20'hABCDE, 31'h0FFF));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h1234_5678, 20'h00001,
                               31'h7FFF_F000));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h1234_5678, 20'h00002, 31'h2000));
        issue_request(make_req(sscrt_pkg::KIND_OPEN,  32'h8765_4321, 20'h80000,
                               31'h4000_0000));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h0, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h1234_5678, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h1234_5678, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, 32'h8765_4321, 20'h0, 31'h0));
    endtask

    // Fill every entry, hit the full table, then drain it again
    task automatic test_table_full();
        logic [31:0] id;
        int          tries;
        int          i;
        int          refs;
        idle_pct = 34;
        tries    = 0;
        while (tries < 200 && count_free() != 0) begin
            do id = $urandom(); while (id == 32'h0);
            issue_request(make_req(sscrt_pkg::KIND_OPEN, id, 20'($urandom()),
                                   31'($urandom())));
            tries++;
        end
        // table full takes priority over space full
        issue_request(make_req(sscrt_pkg::KIND_OPEN, $urandom() | 32'h1, 20'hFFFFF,
                               31'h7FFF_FFFF));
        issue_request(make_req(sscrt_pkg::KIND_OPEN, $urandom() | 32'h1, 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_OPEN, shadow_id[10], 20'h0, 31'h1));
        issue_request(make_req(sscrt_pkg::KIND_CLOSE, shadow_id[20], 20'h0, 31'h0));
        issue_request(make_req(sscrt_pkg::KIND_OPEN, $urandom() | 32'h1, 20'($urandom()),
                               31'h3));
        for (i = 0; i < ENTRIES; i++) begin
            id   = shadow_id[i];
            refs = shadow_refs[i];
            repeat (refs) issue_request(make_req(sscrt_pkg::KIND_CLOSE, id, 20'h0, 31'h0));
        end
    endtask

    // Open/close traffic over a pool of ids with some noise
    task automatic test_random_traffic(input int idle, input int pool_n,
                                       input int open_pct, input int count);
        logic [31:0] id;
        logic [30:0] psize;
        logic        kind;
        int          pick;
        idle_pct = idle;
        repeat (count) begin
            kind = ($urandom_range(99) < open_pct) ? sscrt_pkg::KIND_OPEN
                                                   : sscrt_pkg::KIND_CLOSE;
            pick = $urandom_range(99);
            if (pick < 8)       id = $urandom();
            else if (pick < 10) id = 32'h0;
            else                id = id_pool[$urandom_range(pool_n - 1)];
            case ($urandom_range(9))
                0:       psize = 31'h7FFF_D000 + 31'($urandom_range(12287));
                1:       psize = 31'($urandom_range(8192));
                default: psize = 31'($urandom());
            endcase
            issue_request(make_req(kind, id, 20'($urandom()), psize));
        end
    endtask

    initial begin
        apply_reset();
        test_directed();
        test_table_full();
        test_random_traffic(0,  16, 50, 275);
        test_random_traffic(55, 96, 70, 275);
        test_random_traffic(34, 40, 45, 275);
        test_random_traffic(0,  96, 65, 275);
        test_random_traffic(55, 16, 55, 275);
        test_random_traffic(34, 40, 40, 275);
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (pending_replies.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_replies.size()));
        $display("Covered %0d requests: %0d new, %0d existing, %0d table full, %0d space full,",
                 request_count, status_seen[sscrt_pkg::ST_NEW],
                 status_seen[sscrt_pkg::ST_EXISTING],
                 status_seen[sscrt_pkg::ST_TABLE_FULL], status_seen[sscrt_pkg::ST_SPACE_FULL]);
        $display("  %0d decremented, %0d freed, %0d not found; %0d mismatches.",
                 status_seen[sscrt_pkg::ST_DECREMENTED], status_seen[sscrt_pkg::ST_FREED],
                 status_seen[sscrt_pkg::ST_NOT_FOUND], error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                 pending_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
